FILE: rtl/tad_pkg.sv
// shared types, constants and tables for the tilt angle detector
package tad_pkg;

  localparam int ZFrac = 20;
  localparam int OpMeasure = 0;
  localparam logic OP_CAPTURE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_NORM,
    ST_SQ,
    ST_SQRT,
    ST_CORDIC,
    ST_FINISH,
    ST_OUT
  } tad_state_t;

  // atan(2^-i) in degrees scaled by 2^20
  function automatic logic [26:0] atan_deg(input logic [4:0] i);
    logic [26:0] v;
    begin
      case (i)
        5'd0: v = 27'd47185920;
        5'd1: v = 27'd27855475;
        5'd2: v = 27'd14718068;
        5'd3: v = 27'd7471121;
        5'd4: v = 27'd3750058;
        5'd5: v = 27'd1876857;
        5'd6: v = 27'd938658;
        5'd7: v = 27'd469357;
        5'd8: v = 27'd234682;
        5'd9: v = 27'd117342;
        5'd10: v = 27'd58671;
        5'd11: v = 27'd29335;
        5'd12: v = 27'd14668;
        5'd13: v = 27'd7334;
        5'd14: v = 27'd3667;
        5'd15: v = 27'd1833;
        5'd16: v = 27'd917;
        5'd17: v = 27'd458;
        5'd18: v = 27'd229;
        5'd19: v = 27'd115;
        5'd20: v = 27'd57;
        5'd21: v = 27'd29;
        5'd22: v = 27'd14;
        5'd23: v = 27'd7;
        default: v = 27'd0;
      endcase
      return v;
    end
  endfunction

endpackage

FILE: rtl/tad_mac.sv
// shared signed multiplier with accumulator, one product per cycle while en is high
module tad_mac #(
  parameter int AW = 16,
  parameter int PW = 64
) (
  input  logic                 clk,
  input  logic                 clr,
  input  logic                 en,
  input  logic                 neg,
  input  logic signed [AW:0]   op_a,
  input  logic signed [AW:0]   op_b,
  output logic signed [PW-1:0] acc
);
  logic signed [2*AW+1:0] prod;
  logic signed [PW-1:0]   prod_x;
  logic signed [PW-1:0]   acc_r;

  assign prod = op_a * op_b;
  assign prod_x = PW'(prod);

  always_ff @(posedge clk) begin
    if (clr) begin
      acc_r <= '0;
    end else if (en) begin
      acc_r <= neg ? acc_r - prod_x : acc_r + prod_x;
    end
  end

  assign acc = acc_r;
endmodule

FILE: rtl/tilt_angle_detector.sv
// top level of the tilt angle detector
// Computes the angle between an accelerometer sample and a stored reference.
// Input beat on in_: tdata carries accel_x, accel_y, accel_z; tuser is the
// opcode (1 captures the sample as reference, 0 measures against it).
// Result beat on out_: tdata holds angle (degrees, ANGLE_FRAC_BITS fraction
// bits), tuser holds over_threshold, degenerate, captured.
// The threshold register is written through cfg_wr_en / cfg_wr_data.
// A capture or a degenerate measure shows its result the cycle after it is
// accepted. A full measure runs in steps: the nine products on the shared
// multiplier with four accumulator reads, normalisation, 3 squares on a
// 30-bit squarer, the bit-pair square root, CORDIC_STEPS steps on one
// add/shift unit and the final rounding. One item is in flight at a time;
// in_tready is low while it is worked on and while its result waits, and
// the next beat can be taken in the cycle after the result is taken. A
// stalled receiver holds the result in the output register. Reset clears
// the reference to zero, sets the threshold to 45 degrees and empties the
// block.
module tilt_angle_detector #(
  parameter int AXIS_BITS = 16,
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [3*AXIS_BITS-1:0] in_tdata,   // accel_x, accel_y, accel_z
  input  logic                   in_tuser,   // opcode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [15:0]            out_tdata,  // angle, zero pad
  output logic [2:0]             out_tuser,  // over_threshold, degenerate, captured
  input  logic                   cfg_wr_en,
  input  logic [14:0]            cfg_wr_data // threshold_angle
);
  import tad_pkg::*;

  localparam int AW = AXIS_BITS;
  localparam int PW = (2 * AW + 4 > 32) ? 2 * AW + 4 : 32;
  localparam int NL = 30;
  localparam int CW = 40;
  localparam int ZW = 32;
  localparam int SW = 5;
  localparam int KSH = ZFrac - ANGLE_FRAC_BITS;
  localparam int QW = 20;

  tad_state_t state_r, state_nxt;

  logic signed [AW-1:0] ax_r, ay_r, az_r, rx_r, ry_r, rz_r;
  logic [14:0] thr_r;
  logic [3:0]  cnt_r;
  logic [5:0]  it_r;
  logic signed [PW-1:0] cx_r, cy_r, cz_r;
  logic [PW-1:0] mx_r, my_r, mz_r, md_r;
  logic dneg_r;
  logic [63:0] sq_r, rem_r, res_r;
  logic [63:0] bit_r;
  logic signed [CW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic [14:0] angle_r;
  logic ovr_r, deg_r, cap_r;

  logic accept;
  logic zero_a;
  logic signed [AW:0] mul_a, mul_b;
  logic mac_clr, mac_en, mac_neg;
  logic signed [PW-1:0] acc;

  assign accept = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign zero_a = (in_tdata == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 15'd5760;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rx_r <= '0;
      ry_r <= '0;
      rz_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept && in_tuser == OP_CAPTURE) begin
        rx_r <= in_tdata[AW-1:0];
        ry_r <= in_tdata[2*AW-1:AW];
        rz_r <= in_tdata[3*AW-1:2*AW];
      end
    end
  end

  // product schedule: cx = ay*rz - az*ry ; cy = az*rx - ax*rz ;
  // cz = ax*ry - ay*rx ; dot = ax*rx + ay*ry + az*rz
  logic signed [AW-1:0] sa, sb;
  always_comb begin
    sa = ax_r;
    sb = rx_r;
    mac_neg = 1'b0;
    case (cnt_r)
      4'd0: begin sa = ay_r; sb = rz_r; end
      4'd1: begin sa = az_r; sb = ry_r; mac_neg = 1'b1; end
      4'd2: begin sa = az_r; sb = rx_r; end
      4'd3: begin sa = ax_r; sb = rz_r; mac_neg = 1'b1; end
      4'd4: begin sa = ax_r; sb = ry_r; end
      4'd5: begin sa = ay_r; sb = rx_r; mac_neg = 1'b1; end
      4'd6: begin sa = ax_r; sb = rx_r; end
      4'd7: begin sa = ay_r; sb = ry_r; end
      4'd8: begin sa = az_r; sb = rz_r; end
      default: begin sa = ax_r; sb = rx_r; end
    endcase
  end
  assign mul_a = (AW+1)'(sa);
  assign mul_b = (AW+1)'(sb);
  assign mac_en = (state_r == ST_MUL);
  assign mac_clr = (state_r == ST_IDLE) || (state_r == ST_ACC);

  tad_mac #(.AW(AW), .PW(PW)) u_mac (
    .clk(clk), .clr(mac_clr), .en(mac_en), .neg(mac_neg),
    .op_a(mul_a), .op_b(mul_b), .acc(acc)
  );

  // normalisation
  logic [PW-1:0] big;
  logic [SW-1:0] s_shift;
  always_comb begin
    big = mx_r;
    if (my_r > big) big = my_r;
    if (mz_r > big) big = mz_r;
    if (md_r > big) big = md_r;
    s_shift = '0;
    for (int j = PW - 1; j >= NL; j--) begin
      if (big[j] && s_shift == '0) s_shift = SW'(j - NL + 1);
    end
  end

  // squares of the 30-bit magnitudes, one per cycle on a dedicated squarer
  logic [29:0] sq_op;
  logic [59:0] sq_prod;
  always_comb begin
    case (cnt_r)
      4'd0: sq_op = mx_r[29:0];
      4'd1: sq_op = my_r[29:0];
      default: sq_op = mz_r[29:0];
    endcase
  end
  assign sq_prod = sq_op * sq_op;

  // integer square root step
  logic [63:0] trial;
  assign trial = res_r + bit_r;

  // cordic step
  logic signed [CW-1:0] xs, ys;
  logic [4:0] ci;
  logic signed [ZW-1:0] t_step;
  assign ci = it_r[4:0];
  assign xs = x_r >>> ci;
  assign ys = y_r >>> ci;
  assign t_step = ZW'(atan_deg(ci));

  // final angle
  logic signed [ZW-1:0] zf, zc;
  logic [ZW-1:0] zq;
  logic [QW-1:0] q;
  always_comb begin
    zf = dneg_r ? ((ZW'(180) <<< ZFrac) - z_r) : z_r;
    zc = zf;
    if (zf < 0) zc = '0;
    if (zf > (ZW'(180) <<< ZFrac)) zc = ZW'(180) <<< ZFrac;
    zq = (ZW'(zc) + (ZW'(1) << (KSH - 1))) >> KSH;
    q = QW'(zq);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser == OP_CAPTURE || zero_a || (rx_r == '0 && ry_r == '0 && rz_r == '0))
            state_nxt = ST_OUT;
          else
            state_nxt = ST_MUL;
        end
      end
      ST_MUL: if (cnt_r == 4'd1 || cnt_r == 4'd3 || cnt_r == 4'd5 || cnt_r == 4'd8)
        state_nxt = ST_ACC;
      ST_ACC: state_nxt = (cnt_r == 4'd9) ? ST_NORM : ST_MUL;
      ST_NORM: state_nxt = ST_SQ;
      ST_SQ: if (cnt_r == 4'd2) state_nxt = ST_SQRT;
      ST_SQRT: if (bit_r == '0) state_nxt = ST_CORDIC;
      ST_CORDIC: if (it_r == 6'(CORDIC_STEPS - 1)) state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_OUT;
      ST_OUT: if (out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        cnt_r <= '0;
        it_r <= '0;
        ax_r <= in_tdata[AW-1:0];
        ay_r <= in_tdata[2*AW-1:AW];
        az_r <= in_tdata[3*AW-1:2*AW];
        angle_r <= '0;
        ovr_r <= 1'b0;
        cap_r <= (in_tuser == OP_CAPTURE);
        deg_r <= zero_a || (in_tuser != OP_CAPTURE &&
                 rx_r == '0 && ry_r == '0 && rz_r == '0);
      end
      ST_MUL: cnt_r <= cnt_r + 4'd1;
      ST_ACC: begin
        case (cnt_r)
          4'd2: cx_r <= acc;
          4'd4: cy_r <= acc;
          4'd6: cz_r <= acc;
          default: begin
            md_r <= acc[PW-1] ? PW'(-acc) : PW'(acc);
            dneg_r <= acc[PW-1];
            mx_r <= cx_r[PW-1] ? PW'(-cx_r) : PW'(cx_r);
            my_r <= cy_r[PW-1] ? PW'(-cy_r) : PW'(cy_r);
            mz_r <= cz_r[PW-1] ? PW'(-cz_r) : PW'(cz_r);
            cnt_r <= 4'd9;
          end
        endcase
      end
      ST_NORM: begin
        mx_r <= mx_r >> s_shift;
        my_r <= my_r >> s_shift;
        mz_r <= mz_r >> s_shift;
        md_r <= md_r >> s_shift;
        cnt_r <= '0;
        sq_r <= '0;
      end
      ST_SQ: begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd2) begin
          rem_r <= sq_r + 64'(sq_prod);
          res_r <= '0;
          bit_r <= 64'd1 << 62;
        end else begin
          sq_r <= sq_r + 64'(sq_prod);
        end
      end
      ST_SQRT: begin
        if (bit_r != '0) begin
          if (rem_r >= trial) begin
            rem_r <= rem_r - trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end
        x_r <= CW'(md_r[NL-1:0]);
        y_r <= CW'(res_r);
        z_r <= '0;
      end
      ST_CORDIC: begin
        it_r <= it_r + 6'd1;
        if (y_r > 0) begin
          x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + t_step;
        end else begin
          x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - t_step;
        end
      end
      ST_FINISH: begin
        angle_r <= (q > QW'(16'h7FFF)) ? 15'h7FFF : q[14:0];
        ovr_r <= ((q > QW'(16'h7FFF)) ? 15'h7FFF : q[14:0]) > thr_r;
      end
      default: ;
    endcase
  end

  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata = {1'b0, angle_r};
  assign out_tuser = {cap_r, deg_r, ovr_r};

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("ready during result");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
  a_cap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[2] || out_tuser[1]) |-> out_tdata == '0)
    else $error("capture or degenerate with angle");
endmodule

FILE: tb/sv/tb_tilt_angle_detector.sv
// testbench for the tilt angle detector: random and directed beats checked against a predictor
`timescale 1ns / 100ps

module tb_tilt_angle_detector;
  import tad_pkg::*;

  typedef struct packed {
    logic        op;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
  } sample_t;

  typedef struct packed {
    logic [14:0] angle;
    logic        over;
    logic        degen;
    logic        capt;
  } tilt_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [2:0] out_tuser;
  logic cfg_wr_en = 1'b0;
  logic [14:0] cfg_wr_data = '0;

  tilt_angle_detector dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sample_t pending_samples[$];
  tilt_res_t expected_tilts[$];
  longint ref_vx, ref_vy, ref_vz;
  logic [14:0] thresh;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int n_measured = 0;
  int n_captured = 0;
  int n_degen = 0;
  int quiet_cycles = 0;

  function automatic longint isqrt(longint v);
    longint res, bt;
    res = 0;
    bt = 64'sd1 <<< 62;
    while (bt > v) bt = bt >>> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >>> 1) + bt;
      end else begin
        res = res >>> 1;
      end
      bt = bt >>> 2;
    end
    return res;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [14:0] tilt_between(longint ax, longint ay, longint az);
    longint cx, cy, cz, dot, mx, my, mz, md, big, x, y, z, xs, ys, q;
    int s;
    cx = ay * ref_vz - az * ref_vy;
    cy = az * ref_vx - ax * ref_vz;
    cz = ax * ref_vy - ay * ref_vx;
    dot = ax * ref_vx + ay * ref_vy + az * ref_vz;
    mx = mag(cx); my = mag(cy); mz = mag(cz); md = mag(dot);
    big = mx;
    if (my > big) big = my;
    if (mz > big) big = mz;
    if (md > big) big = md;
    s = 0;
    while ((big >>> s) >= (64'sd1 <<< 30)) s++;
    mx = mx >>> s; my = my >>> s; mz = mz >>> s; md = md >>> s;
    x = md;
    y = isqrt(mx * mx + my * my + mz * mz);
    z = 0;
    for (int i = 0; i < 16; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += longint'(atan_deg(i[4:0]));
      end else begin
        x -= ys; y += xs; z -= longint'(atan_deg(i[4:0]));
      end
    end
    if (dot < 0) z = (64'sd180 <<< ZFrac) - z;
    if (z < 0) z = 0;
    if (z > (64'sd180 <<< ZFrac)) z = 64'sd180 <<< ZFrac;
    q = (z + (64'sd1 <<< 12)) >>> 13;
    if (q > 32767) q = 32767;
    return q[14:0];
  endfunction

  function automatic tilt_res_t predict_tilt(sample_t smp);
    tilt_res_t r;
    longint ax, ay, az;
    bit zero_a;
    ax = longint'($signed(smp.ax));
    ay = longint'($signed(smp.ay));
    az = longint'($signed(smp.az));
    zero_a = (ax == 0 && ay == 0 && az == 0);
    r = '0;
    if (smp.op == OP_CAPTURE) begin
      ref_vx = ax; ref_vy = ay; ref_vz = az;
      r.degen = zero_a;
      r.capt = 1'b1;
    end else if (zero_a || (ref_vx == 0 && ref_vy == 0 && ref_vz == 0)) begin
      r.degen = 1'b1;
    end else begin
      r.angle = tilt_between(ax, ay, az);
      r.over = r.angle > thresh;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sample_t acc;
        acc = {in_tuser, in_tdata[15:0], in_tdata[31:16], in_tdata[47:32]};
        expected_tilts.push_back(predict_tilt(acc));
        if (acc.op == OP_CAPTURE) n_captured++; else n_measured++;
      end
      if ((!in_tvalid || in_tready) && pending_samples.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        sample_t nx;
        nx = pending_samples.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= nx.op;
        in_tdata <= {nx.az, nx.ay, nx.ax};
      end else if (!in_tvalid || in_tready) begin
        in_tvalid <= 1'b0;
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        quiet_cycles <= 0;
        if (expected_tilts.size() == 0) begin
          report_mismatch("unexpected beat", out_tdata, -1);
        end else begin
          tilt_res_t e;
          e = expected_tilts.pop_front();
          if (out_tdata[14:0] != e.angle) report_mismatch("angle", out_tdata[14:0], e.angle);
          if (out_tdata[15] != 1'b0) report_mismatch("pad", out_tdata[15], 0);
          if (out_tuser[0] != e.over) report_mismatch("over_threshold", out_tuser[0], e.over);
          if (out_tuser[1] != e.degen) report_mismatch("degenerate", out_tuser[1], e.degen);
          if (out_tuser[2] != e.capt) report_mismatch("captured", out_tuser[2], e.capt);
          if (e.degen) n_degen++;
        end
      end else if (in_tvalid && in_tready) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_sample(logic op, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    sample_t s;
    s.op = op; s.ax = x; s.ay = y; s.az = z;
    pending_samples.push_back(s);
  endtask

  task automatic drain();
    wait (pending_samples.size() == 0 && !in_tvalid && expected_tilts.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_threshold(logic [14:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    thresh = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [14:0] thr_set[4];
    int pcts_send[4];
    int pcts_recv[4];
    ref_vx = 0; ref_vy = 0; ref_vz = 0;
    thresh = 15'd5760;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: measure before any capture, extremes, parallel, opposite, orthogonal
    push_sample(1'b0, 16'd100, 16'd5, 16'd7);
    push_sample(1'b1, 16'd0, 16'd0, 16'd0);
    push_sample(1'b0, 16'd1, 16'd0, 16'd0);
    push_sample(1'b1, 16'h7fff, 16'h7fff, 16'h7fff);
    push_sample(1'b0, 16'h7fff, 16'h7fff, 16'h7fff);
    push_sample(1'b0, 16'h8000, 16'h8000, 16'h8000);
    push_sample(1'b0, 16'h0000, 16'h0000, 16'h0000);
    push_sample(1'b0, 16'h8000, 16'h7fff, 16'h0001);
    push_sample(1'b1, 16'h8000, 16'h8000, 16'h8000);
    push_sample(1'b0, 16'h7fff, 16'h8000, 16'h7fff);
    push_sample(1'b0, 16'hffff, 16'hffff, 16'hffff);
    push_sample(1'b1, 16'd1000, 16'd0, 16'd0);
    push_sample(1'b0, 16'd0, 16'd1000, 16'd0);
    push_sample(1'b0, 16'd1000, 16'd1000, 16'd0);
    push_sample(1'b0, 16'd1000, 16'd1001, 16'd0);
    push_sample(1'b0, 16'hfc18, 16'd1, 16'd0);
    push_sample(1'b0, 16'hfc18, 16'd0, 16'd0);
    push_sample(1'b0, 16'd0, 16'd0, 16'h5555);
    push_sample(1'b0, 16'haaaa, 16'h5555, 16'haaaa);
    drain();

    thr_set = '{15'd0, 15'd23040, 15'h7fff, 15'd9000};
    pcts_send = '{0, 62, 0, 20};
    pcts_recv = '{0, 0, 62, 20};
    for (int ph = 0; ph < 4; ph++) begin
      write_threshold(thr_set[ph]);
      send_idle_pct = pcts_send[ph];
      recv_stall_pct = pcts_recv[ph];
      for (int n = 0; n < 110; n++) begin
        if ($urandom_range(5) == 0) push_sample(1'b1, rand_axis(), rand_axis(), rand_axis());
        else push_sample(1'b0, rand_axis(), rand_axis(), rand_axis());
        if (n == 55) begin
          // hold back until every result is home
          wait (pending_samples.size() == 0 && !in_tvalid && expected_tilts.size() == 0);
        end
      end
      drain();
    end

    $display("covered %0d measures and %0d captures, %0d degenerate results",
             n_measured, n_captured, n_degen);
    $display("four threshold settings with sender and receiver idling mixed");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
